// File: rtl/core/wda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wda_pkg: shared definitions for the windowed defect alarm
// Sizes, operation codes, controller states and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wda_pkg;

  // Window geometry.
  localparam int WINDOW    = 16;
  localparam int POSITIONS = 16;
  localparam int CAMERAS   = 2;

  // Fixed field widths of the ports.
  localparam int OP_W   = 2;
  localparam int CAM_W  = 1;
  localparam int MASK_W = 16;
  localparam int THR_W  = 5;

  // Derived widths.
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CAMIDX_W = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4);

  typedef logic [POSITIONS-1:0] pos_mask_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CAMIDX_W-1:0]  cam_idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  localparam idx_t IDX_LAST = idx_t'(WINDOW - 1);

  // Operation codes of the input word.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     push;        // shift the incoming mask into a window
    logic     clear;       // zero every window
    logic     cnt_clear;   // zero the position counters and latch the camera
    logic     scan_en;     // add one window entry to the counters
    idx_t     scan_idx;    // entry being added
    logic     out_load;    // load the result register
    logic     use_check;   // result comes from the counters, else it is 1
  } wda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;        // result register can take a word this cycle
  } wda_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/wda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wda_ctrl: controller for the windowed defect alarm
// Decodes each accepted word, walks the window during a check and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module wda_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [wda_pkg::OP_W-1:0]   in_operation,
  input  wire logic [wda_pkg::CAM_W-1:0]  in_camera,
  input  wire wda_pkg::wda_stat_t         stat,
  output wda_pkg::wda_cmd_t               cmd
);

  wda_pkg::state_t state_r, state_nxt;
  wda_pkg::idx_t   idx_r, idx_nxt;
  logic            chk_r, chk_nxt;
  logic            cam_ok;
  wda_pkg::op_t    op;

  assign op     = wda_pkg::op_t'(in_operation);
  assign cam_ok = (32'(in_camera) < 32'(wda_pkg::CAMERAS));

  // State, scan index and result source registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wda_pkg::ST_IDLE;
      idx_r   <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      chk_r   <= chk_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    chk_nxt       = chk_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.scan_idx  = idx_r;
    cmd.use_check = chk_r;
    unique case (state_r)
      wda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          chk_nxt   = 1'b0;
          state_nxt = wda_pkg::ST_DONE;
          unique case (op)
            wda_pkg::OP_PUSH: begin
              cmd.push = cam_ok;
            end
            wda_pkg::OP_CHECK: begin
              if (cam_ok) begin
                cmd.cnt_clear = 1'b1;
                chk_nxt       = 1'b1;
                idx_nxt       = '0;
                state_nxt     = wda_pkg::ST_SCAN;
              end
            end
            wda_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      wda_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == wda_pkg::IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = wda_pkg::ST_DONE;
        end
      end
      wda_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = wda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/wda_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wda_datapath: windows, position counters and result register
// Holds each camera's window as a shift line, counts bad marks per position
// one entry a cycle, and compares the counts with the alarm threshold.
// ----------------------------------------------------------------------------
module wda_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [wda_pkg::CAM_W-1:0]   in_camera,
  input  wire logic [wda_pkg::MASK_W-1:0]  in_result_mask,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wda_pkg::THR_W-1:0]   cfg_wr_data,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_window_ok,
  input  wire wda_pkg::wda_cmd_t           cmd,
  output wda_pkg::wda_stat_t               stat
);

  wda_pkg::pos_mask_t win_r [wda_pkg::CAMERAS][wda_pkg::WINDOW];
  wda_pkg::cnt_t      cnt_r [wda_pkg::POSITIONS];
  wda_pkg::cam_idx_t  cam_r;
  wda_pkg::cam_idx_t  in_cam_idx;
  logic [wda_pkg::THR_W-1:0] thr_r;
  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic               hit;
  wda_pkg::pos_mask_t scan_word;

  assign in_cam_idx = wda_pkg::cam_idx_t'(in_camera);

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= wda_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Windows: a push shifts the oldest entry out, a clear zeroes all of them.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int c = 0; c < wda_pkg::CAMERAS; c++) begin
        for (int k = 0; k < wda_pkg::WINDOW; k++) begin
          win_r[c][k] <= '0;
        end
      end
    end else if (cmd.push) begin
      for (int k = 0; k < wda_pkg::WINDOW - 1; k++) begin
        win_r[in_cam_idx][k] <= win_r[in_cam_idx][k+1];
      end
      win_r[in_cam_idx][wda_pkg::WINDOW-1] <= wda_pkg::pos_mask_t'(in_result_mask);
    end
  end

  // Entry under scan for the latched camera.
  assign scan_word = win_r[cam_r][cmd.scan_idx];

  // Camera latch and per-position counters.
  always_ff @(posedge clk) begin
    if (cmd.cnt_clear) begin
      cam_r <= in_cam_idx;
      for (int p = 0; p < wda_pkg::POSITIONS; p++) begin
        cnt_r[p] <= '0;
      end
    end else if (cmd.scan_en) begin
      for (int p = 0; p < wda_pkg::POSITIONS; p++) begin
        cnt_r[p] <= cnt_r[p] + wda_pkg::cnt_t'(scan_word[p]);
      end
    end
  end

  // Any position whose count reached the threshold raises the alarm.
  always_comb begin
    hit = 1'b0;
    for (int p = 0; p < wda_pkg::POSITIONS; p++) begin
      if (wda_pkg::cmp_t'(cnt_r[p]) >= wda_pkg::cmp_t'(thr_r)) begin
        hit = 1'b1;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = cmd.use_check ? !hit : 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_window_ok = ok_r;

endmodule

`default_nettype wire

// File: rtl/core/windowed_defect_alarm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_defect_alarm: sliding-window defect alarm for two cameras
// Keeps the last inspection masks of each camera and raises an alarm when
// any position collects too many bad marks within the window.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Handshake
//  input     in_operation, in_camera, in_result_mask       in_valid / in_ready
//  result    out_window_ok                                 out_valid / out_ready
//  config    cfg_wr_data (alarm threshold)                 cfg_wr_en
//
//  A check scans the window, reading one window entry per cycle; a push, clear
//  or unused operation does no scan. Reset clears both windows and sets the
//  threshold to 4. A new word is taken while the previous result waits in the
//  output register; the next result waits in the controller until that
//  register is free.
// ----------------------------------------------------------------------------
module windowed_defect_alarm (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [wda_pkg::OP_W-1:0]    in_operation,
  input  wire logic [wda_pkg::CAM_W-1:0]   in_camera,
  input  wire logic [wda_pkg::MASK_W-1:0]  in_result_mask,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_window_ok,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wda_pkg::THR_W-1:0]   cfg_wr_data
);

  wda_pkg::wda_cmd_t  cmd;
  wda_pkg::wda_stat_t stat;

  // Controller.
  wda_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_camera    (in_camera),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath.
  wda_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_camera      (in_camera),
    .in_result_mask (in_result_mask),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_window_ok  (out_window_ok),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

`default_nettype wire

// File: bench/wda_alarm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wda_alarm_checker: window_ok predictor and comparator
// Watches the input, result and threshold ports of the windowed defect
// alarm. It keeps its own copy of both camera windows and of the threshold,
// and it works out window_ok for every accepted input word. Each accepted
// result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module wda_alarm_checker
  import wda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [CAM_W-1:0]  in_camera,
  input  wire logic [MASK_W-1:0] in_result_mask,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_window_ok,
  input  wire logic              cfg_wr_en,
  input  wire logic [THR_W-1:0]  cfg_wr_data,
  output int                     fail_count,
  output int                     words_pending
);

  // Shadow copy of the block state.
  pos_mask_t         mask_windows [CAMERAS][WINDOW];
  logic [THR_W-1:0]  alarm_thr;

  // Predicted window_ok of every word that has gone in but not come out.
  logic              ok_expected [$];
  int                failures;

  task automatic clear_windows();
    for (int c = 0; c < CAMERAS; c++) begin
      for (int k = 0; k < WINDOW; k++) begin
        mask_windows[c][k] = '0;
      end
    end
  endtask

  // Track every handshake at the rising edge.
  always @(posedge clk) begin : track
    int       count;
    logic     ok;
    logic     want;
    cam_idx_t cam;

    if (!rst_n) begin
      clear_windows();
      alarm_thr = THR_RESET;
      ok_expected.delete();
      failures = 0;
    end else begin
      if (cfg_wr_en) begin
        alarm_thr = cfg_wr_data;
      end

      // Compare a result word with the oldest prediction.
      if (out_valid && out_ready) begin
        if (ok_expected.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result word: window_ok %0b", out_window_ok);
          end
          failures++;
        end else begin
          want = ok_expected.pop_front();
          if (out_window_ok !== want) begin
            if (failures < 10) begin
              $display("window_ok mismatch: expected %0b, got %0b", want, out_window_ok);
            end
            failures++;
          end
        end
      end

      // Predict the result of an input word and update the shadow windows.
      if (in_valid && in_ready) begin
        cam = cam_idx_t'(in_camera);
        ok  = 1'b1;
        case (op_t'(in_operation))
          OP_PUSH: begin
            if (int'(cam) < CAMERAS) begin
              for (int k = 0; k < WINDOW - 1; k++) begin
                mask_windows[cam][k] = mask_windows[cam][k+1];
              end
              mask_windows[cam][WINDOW-1] = pos_mask_t'(in_result_mask);
            end
          end
          OP_CHECK: begin
            if (int'(cam) < CAMERAS) begin
              for (int p = 0; p < POSITIONS; p++) begin
                count = 0;
                for (int k = 0; k < WINDOW; k++) begin
                  count += int'(mask_windows[cam][k][p]);
                end
                if (count >= int'(alarm_thr)) begin
                  ok = 1'b0;
                end
              end
            end
          end
          OP_CLEAR: begin
            clear_windows();
          end
          default: begin
          end
        endcase
        ok_expected.push_back(ok);
      end
    end

    fail_count    <= failures;
    words_pending <= ok_expected.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_windowed_defect_alarm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_windowed_defect_alarm: testbench of the windowed defect alarm
// Drives directed and random push, check, clear and unused words under
// several alarm thresholds, with random idling on both channels. A separate
// checker predicts every window_ok and compares it with the block's output.
// ----------------------------------------------------------------------------
module tb_windowed_defect_alarm;
  import wda_pkg::*;

  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 157;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation   = '0;
  logic [CAM_W-1:0]  in_camera      = '0;
  logic [MASK_W-1:0] in_result_mask = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_window_ok;
  logic              cfg_wr_en      = 1'b0;
  logic [THR_W-1:0]  cfg_wr_data    = '0;

  int                fail_count;
  int                words_pending;
  int                send_idle_pct  = 16;
  int                recv_idle_pct  = 70;
  int                quiet_cycles   = 0;

  always #1 clk = ~clk;

  windowed_defect_alarm dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_camera      (in_camera),
    .in_result_mask (in_result_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_ok  (out_window_ok),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  wda_alarm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_camera      (in_camera),
    .in_result_mask (in_result_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_ok  (out_window_ok),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .words_pending  (words_pending)
  );

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one input word, after a random gap, and wait until it is taken.
  task automatic send_word(input op_t op, input logic [CAM_W-1:0] cam,
                           input logic [MASK_W-1:0] mask);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_camera      <= cam;
    in_result_mask <= mask;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every result word drain, then write the alarm threshold.
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    pos_mask_t        defect_pattern [CAMERAS];
    logic [CAM_W-1:0] cam;
    logic [MASK_W-1:0] mask;
    logic [THR_W-1:0] thr;
    int               pick;
    op_t              op;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset threshold of four.
    send_word(OP_CHECK, 1'b0, 16'h0000);
    repeat (3) send_word(OP_PUSH, 1'b0, 16'hFFFF);
    send_word(OP_CHECK, 1'b0, 16'h0000);
    send_word(OP_PUSH, 1'b0, 16'h8001);
    send_word(OP_CHECK, 1'b0, 16'hFFFF);
    send_word(OP_CHECK, 1'b1, 16'h0000);
    send_word(OP_NONE, 1'b1, 16'hFFFF);
    send_word(OP_CHECK, 1'b1, 16'h0000);
    send_word(OP_PUSH, 1'b1, 16'h5555);
    send_word(OP_PUSH, 1'b1, 16'hAAAA);
    send_word(OP_CLEAR, 1'b1, 16'hFFFF);
    send_word(OP_CHECK, 1'b0, 16'h0000);

    // A zero threshold always alarms; one above the window never does.
    write_threshold(5'd0);
    send_word(OP_CHECK, 1'b1, 16'h0000);
    write_threshold(5'd31);
    send_word(OP_PUSH, 1'b0, 16'hFFFF);
    send_word(OP_CHECK, 1'b0, 16'h0000);

    // Random phases, each under its own threshold and idling mode.
    cam = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       thr = THR_RESET;
        1:       thr = 5'd1;
        2:       thr = 5'd16;
        3:       thr = 5'd17;
        4:       thr = 5'd0;
        5:       thr = 5'd15;
        default: thr = ($urandom_range(3) == 0) ? THR_W'($urandom_range(31))
                                                : THR_W'($urandom_range(16, 1));
      endcase
      write_threshold(thr);

      if (ph < 4) begin
        send_idle_pct = 16;
        recv_idle_pct = 70;
      end else if (ph < 8) begin
        send_idle_pct = 70;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Each camera gets a sparse defect pattern that recurs in its masks.
      for (int c = 0; c < CAMERAS; c++) begin
        defect_pattern[c] = pos_mask_t'($urandom & $urandom);
      end

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 20) cam = ~cam;

        case ($urandom_range(9))
          0:       mask = '0;
          1:       mask = '1;
          2, 3:    mask = MASK_W'($urandom);
          default: mask = defect_pattern[cam] | MASK_W'($urandom & $urandom & $urandom);
        endcase

        pick = $urandom_range(99);
        if (pick < 60)      op = OP_PUSH;
        else if (pick < 93) op = OP_CHECK;
        else if (pick < 94) op = OP_CLEAR;
        else if (pick < 97) op = OP_NONE;
        else                op = op_t'($urandom_range(3));

        send_word(op, cam, mask);
      end
    end

    // Wait for the last result words, then give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
